FILE: rtl/dns_name_to_wire_encoder_core_macros.svh
// Assertion macros shared by the checker of the DNS name wire encoder.
`ifndef DNS_NAME_TO_WIRE_ENCODER_CORE_MACROS_SVH
`define DNS_NAME_TO_WIRE_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DNSENC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DNSENC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dnsenc_pkg.sv
// Shared constants, types and helper functions of the DNS name wire encoder.
package dnsenc_pkg;

    localparam int MAX_LABEL_LEN = 63;
    localparam int MAX_WIRE_LEN  = 255;

    localparam int COUNT_W = $clog2(MAX_LABEL_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LABEL_LEN);
    localparam int WIRE_W  = $clog2(MAX_WIRE_LEN + 1);
    localparam int SUM_W   = $clog2(MAX_WIRE_LEN + MAX_LABEL_LEN + 3);

    localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_char;
        logic mark_dot;
        logic set_sent;
        logic name_clear;
        logic set_discard;
        logic clr_discard;
        logic start_emit;
        logic finish_label;
        logic push_len;
        logic push_data;
        logic push_root;
        logic push_err;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic discarding;
        logic prev_dot;
        logic seen_char;
        logic label_sent;
        logic count_zero;
        logic count_full;
        logic count_pre_full;
        logic fits_flush;
        logic fits_end;
        logic fits_full;
        logic root_ok;
        logic is_dot;
        logic char_ok;
        logic char_hyphen;
        logic data_last;
        logic out_free;
    } dp_status_t;

    function automatic logic is_label_char(input logic [7:0] c);
        logic ok;
        ok = c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                       CHAR_HYPHEN, CHAR_UNDERSCORE};
        return ok;
    endfunction

endpackage

FILE: rtl/dnsenc_ctrl.sv
// Controller state machine that sequences label flushes, root and error words.
module dnsenc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_name_end,
    output logic                   s_ready,
    input  dnsenc_pkg::dp_status_t status,
    output dnsenc_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_ROOT,
        ST_ERR
    } state_t;

    state_t state_reg, state_next;
    logic   root_pend_reg, root_pend_next;
    logic   char_bad;

    assign s_ready = (state_reg == ST_IDLE);

    // A character is rejected before it is stored.
    assign char_bad = (status.prev_dot && !status.seen_char) || !status.char_ok ||
                      status.label_sent || status.count_full ||
                      (status.count_zero && status.char_hyphen);

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        root_pend_next = root_pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (status.discarding) begin
                        if (s_name_end) begin
                            cmd.clr_discard = 1'b1;
                            cmd.name_clear  = 1'b1;
                        end
                    end else if (s_name_end) begin
                        if (!status.count_zero) begin
                            if (status.fits_end) begin
                                cmd.start_emit = 1'b1;
                                root_pend_next = 1'b1;
                                state_next     = ST_LEN;
                            end else begin
                                cmd.name_clear = 1'b1;
                                state_next     = ST_ERR;
                            end
                        end else if (status.root_ok) begin
                            state_next = ST_ROOT;
                        end else begin
                            cmd.name_clear = 1'b1;
                            state_next     = ST_ERR;
                        end
                    end else if (status.is_dot) begin
                        if (status.prev_dot ||
                            (!status.count_zero && !status.fits_flush)) begin
                            cmd.name_clear  = 1'b1;
                            cmd.set_discard = 1'b1;
                            state_next      = ST_ERR;
                        end else begin
                            cmd.mark_dot = 1'b1;
                            if (!status.count_zero) begin
                                cmd.start_emit = 1'b1;
                                root_pend_next = 1'b0;
                                state_next     = ST_LEN;
                            end
                        end
                    end else if (char_bad ||
                                 (status.count_pre_full && !status.fits_full)) begin
                        cmd.name_clear  = 1'b1;
                        cmd.set_discard = 1'b1;
                        state_next      = ST_ERR;
                    end else begin
                        cmd.store_char = 1'b1;
                        if (status.count_pre_full) begin
                            cmd.set_sent   = 1'b1;
                            cmd.start_emit = 1'b1;
                            root_pend_next = 1'b0;
                            state_next     = ST_LEN;
                        end
                    end
                end
            end
            ST_LEN: begin
                if (status.out_free) begin
                    cmd.push_len = 1'b1;
                    state_next   = ST_DATA;
                end
            end
            ST_DATA: begin
                if (status.out_free) begin
                    cmd.push_data = 1'b1;
                    if (status.data_last) begin
                        cmd.finish_label = 1'b1;
                        state_next       = root_pend_reg ? ST_ROOT : ST_IDLE;
                    end
                end
            end
            ST_ROOT: begin
                if (status.out_free) begin
                    cmd.push_root  = 1'b1;
                    cmd.name_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (status.out_free) begin
                    cmd.push_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            root_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            root_pend_reg <= root_pend_next;
        end
    end

endmodule

FILE: rtl/dnsenc_datapath.sv
// Datapath: label buffer memory, name bookkeeping, fit checks and output register.
module dnsenc_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_char_byte,
    input  dnsenc_pkg::ctl_cmd_t   cmd,
    output dnsenc_pkg::dp_status_t status,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [7:0]             m_wire_byte,
    output logic                   m_last,
    output logic                   m_error
);

    localparam int CW = dnsenc_pkg::COUNT_W;
    localparam int AW = dnsenc_pkg::ADDR_W;
    localparam int WW = dnsenc_pkg::WIRE_W;
    localparam int SW = dnsenc_pkg::SUM_W;

    logic [7:0] label_mem [0:dnsenc_pkg::MAX_LABEL_LEN-1];

    logic [CW-1:0] count_reg, count_next;
    logic [WW-1:0] wire_reg, wire_next;
    logic          prev_dot_reg, prev_dot_next;
    logic          seen_reg, seen_next;
    logic          sent_reg, sent_next;
    logic          hyphen_reg, hyphen_next;
    logic          discard_reg, discard_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [7:0]    rd_data_reg;

    logic          m_valid_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;
    logic          err_reg;

    logic [SW-1:0] sum_flush;
    logic [CW-1:0] count_m1;
    logic          char_hyphen;
    logic          push;

    assign char_hyphen = (s_char_byte == dnsenc_pkg::CHAR_HYPHEN);
    assign sum_flush   = SW'(wire_reg) + SW'(count_reg) + SW'(1);
    assign count_m1    = count_reg - CW'(1);
    assign push        = cmd.push_len || cmd.push_data || cmd.push_root || cmd.push_err;

    always_comb begin
        status.discarding     = discard_reg;
        status.prev_dot       = prev_dot_reg;
        status.seen_char      = seen_reg;
        status.label_sent     = sent_reg;
        status.count_zero     = (count_reg == '0);
        status.count_full     = (count_reg >= CW'(dnsenc_pkg::MAX_LABEL_LEN));
        status.count_pre_full = (count_reg == CW'(dnsenc_pkg::MAX_LABEL_LEN - 1));
        status.fits_flush     = !hyphen_reg && (sum_flush <= SW'(dnsenc_pkg::MAX_WIRE_LEN));
        status.fits_end       = !hyphen_reg &&
                                (sum_flush + SW'(1) <= SW'(dnsenc_pkg::MAX_WIRE_LEN));
        status.fits_full      = !char_hyphen &&
                                (sum_flush + SW'(1) <= SW'(dnsenc_pkg::MAX_WIRE_LEN));
        status.root_ok        = (SW'(wire_reg) + SW'(1) <= SW'(dnsenc_pkg::MAX_WIRE_LEN));
        status.is_dot         = (s_char_byte == dnsenc_pkg::CHAR_DOT);
        status.char_ok        = dnsenc_pkg::is_label_char(s_char_byte);
        status.char_hyphen    = char_hyphen;
        status.data_last      = (rd_addr_reg == count_m1[AW-1:0]);
        status.out_free       = !m_valid_reg || m_ready;
    end

    always_comb begin
        count_next    = count_reg;
        wire_next     = wire_reg;
        prev_dot_next = prev_dot_reg;
        seen_next     = seen_reg;
        sent_next     = sent_reg;
        hyphen_next   = hyphen_reg;
        discard_next  = discard_reg;
        rd_addr_next  = rd_addr_reg;
        if (cmd.store_char) begin
            count_next    = count_reg + CW'(1);
            seen_next     = 1'b1;
            prev_dot_next = 1'b0;
            hyphen_next   = char_hyphen;
        end
        if (cmd.mark_dot) begin
            prev_dot_next = 1'b1;
            sent_next     = 1'b0;
        end
        if (cmd.set_sent) begin
            sent_next = 1'b1;
        end
        if (cmd.finish_label) begin
            wire_next  = sum_flush[WW-1:0];
            count_next = '0;
        end
        if (cmd.name_clear) begin
            count_next    = '0;
            wire_next     = '0;
            prev_dot_next = 1'b0;
            seen_next     = 1'b0;
            sent_next     = 1'b0;
            hyphen_next   = 1'b0;
        end
        if (cmd.set_discard) begin
            discard_next = 1'b1;
        end else if (cmd.clr_discard) begin
            discard_next = 1'b0;
        end
        if (cmd.start_emit) begin
            rd_addr_next = '0;
        end else if (cmd.push_data) begin
            rd_addr_next = status.data_last ? '0 : rd_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_char) begin
            label_mem[count_reg[AW-1:0]] <= s_char_byte;
        end
        rd_data_reg <= label_mem[rd_addr_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            wire_reg     <= '0;
            prev_dot_reg <= 1'b0;
            seen_reg     <= 1'b0;
            sent_reg     <= 1'b0;
            hyphen_reg   <= 1'b0;
            discard_reg  <= 1'b0;
            rd_addr_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            wire_reg     <= wire_next;
            prev_dot_reg <= prev_dot_next;
            seen_reg     <= seen_next;
            sent_reg     <= sent_next;
            hyphen_reg   <= hyphen_next;
            discard_reg  <= discard_next;
            rd_addr_reg  <= rd_addr_next;
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            last_reg <= cmd.push_root || cmd.push_err;
            err_reg  <= cmd.push_err;
            if (cmd.push_len) begin
                byte_reg <= 8'(count_reg);
            end else if (cmd.push_data) begin
                byte_reg <= rd_data_reg;
            end else begin
                byte_reg <= 8'h00;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_wire_byte = byte_reg;
    assign m_last      = last_reg;
    assign m_error     = err_reg;

endmodule

FILE: rtl/dns_name_to_wire_encoder_core.sv
// Top level of the DNS name to wire-format encoder.
//
//   Channel  Direction  Handshake          Word contents
//   s_       in         s_valid/s_ready    s_char_byte, s_name_end
//   m_       out        m_valid/m_ready    m_wire_byte, m_last, m_error
//
// A character word that causes no output is only buffered. A word that flushes
// a label of k characters sends the length byte and the k label bytes, then the
// root byte when the end word closes the name; an error or a lone root byte is
// a single output word. The label buffer has one write and one read port and
// is read one byte per cycle while m_ready does not stall it, which sets the
// flush rate. Reset (aresetn, synchronous, active low) clears all control
// state; no clearing pass is needed. A stall on m_ready holds the output
// register and the sequencer, and s_ready stays low until the flush completes.
module dns_name_to_wire_encoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_name_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_wire_byte,
    output logic       m_last,
    output logic       m_error
);

    // Commands flow from the controller into the datapath; the datapath
    // answers with classification of the incoming word and fit checks of the
    // buffered label against the per-label and per-name length limits.
    dnsenc_pkg::ctl_cmd_t   cmd;
    dnsenc_pkg::dp_status_t status;

    // The controller decides, for each accepted word, whether to buffer it,
    // start a label flush, close the name with a root byte, or reject the
    // name. Rejections found on a character put the block into discard mode
    // until the end word of that name is seen.
    dnsenc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_name_end (s_name_end),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the label buffer, the byte counters of the current
    // label and name, the name flags and the single output register that
    // decouples the result side from the sequencer.
    dnsenc_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_char_byte (s_char_byte),
        .cmd         (cmd),
        .status      (status),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_wire_byte (m_wire_byte),
        .m_last      (m_last),
        .m_error     (m_error)
    );

endmodule

FILE: rtl/dnsenc_checker.sv
// Port-level checker of the DNS name wire encoder and its bind statement.
`include "dns_name_to_wire_encoder_core_macros.svh"

module dnsenc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_char_byte,
    input logic       s_name_end,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_wire_byte,
    input logic       m_last,
    input logic       m_error
);

    // A waiting input word holds until it is accepted.
    `DNSENC_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_char_byte) && $stable(s_name_end), "input word changed while waiting")

    // A stalled output word holds.
    `DNSENC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_wire_byte) && $stable(m_last) && $stable(m_error), "output word changed while stalled")

    // An error word closes the name and carries a zero byte.
    `DNSENC_ASSERT_NOW(a_err_last, aclk, aresetn, m_valid && m_error, m_last && (m_wire_byte == 8'h00), "error word without last or with data")

    // Label lengths and label characters are never zero, so a zero byte is the root.
    `DNSENC_ASSERT_NOW(a_zero_is_root, aclk, aresetn, m_valid && !m_error && (m_wire_byte == 8'h00), m_last, "zero wire byte that is not the root")

endmodule

bind dns_name_to_wire_encoder_core dnsenc_checker u_dnsenc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_char_byte (s_char_byte),
    .s_name_end  (s_name_end),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_wire_byte (m_wire_byte),
    .m_last      (m_last),
    .m_error     (m_error)
);

FILE: dv/tb_dns_name_to_wire_encoder_core.sv
// Testbench for the DNS name to wire-format encoder: predictor, stimulus and checks.
module tb_dns_name_to_wire_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    // One input word: a name character, or the end marker of a name.
    // hold_for_drain makes the sender wait until every pending output byte
    // has arrived before it offers this word.
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         hold_for_drain;
    } name_word_t;

    // One output word as the encoder should produce it.
    typedef struct {
        logic [7:0] wire_byte;
        logic       last;
        logic       error;
    } wire_result_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte = 8'h00;
    logic       s_name_end  = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_wire_byte;
    logic       m_last;
    logic       m_error;

    name_word_t   pending_words[$];
    wire_result_t expected_bytes[$];
    int           fail_count = 0;

    // Predictor state: the label being collected and the progress of the name.
    logic [7:0] label_buf [dnsenc_pkg::MAX_LABEL_LEN];
    int         label_len      = 0;
    int         wire_len       = 0;
    bit         prev_dot       = 1'b0;
    bit         full_label_out = 1'b0;
    bit         seen_char      = 1'b0;
    bit         dropping       = 1'b0;

    // Sender and receiver pacing.
    int burst_left  = 1;
    int gap_left    = 0;
    int ready_mode  = 0;
    int ready_cycle = 0;

    dns_name_to_wire_encoder_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_byte(s_char_byte),
        .s_name_end (s_name_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_wire_byte(m_wire_byte),
        .m_last     (m_last),
        .m_error    (m_error)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Characters allowed inside a label: letters, digits, underscore, hyphen.
    function automatic bit legal_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == dnsenc_pkg::CHAR_HYPHEN ||
               c == dnsenc_pkg::CHAR_UNDERSCORE;
    endfunction

    // A buffered label may be sent if it is non-empty, does not end in a
    // hyphen, and leaves room for `extra` more bytes within the wire limit.
    function automatic bit label_fits(int extra);
        if (label_len == 0) return 1'b0;
        if (label_buf[label_len - 1] == dnsenc_pkg::CHAR_HYPHEN) return 1'b0;
        return wire_len + 1 + label_len + extra <= dnsenc_pkg::MAX_WIRE_LEN;
    endfunction

    task automatic restart_name();
        label_len      = 0;
        wire_len       = 0;
        prev_dot       = 1'b0;
        full_label_out = 1'b0;
        seen_char      = 1'b0;
    endtask

    // Length byte followed by the buffered label bytes.
    task automatic send_label();
        expected_bytes.push_back('{wire_byte: 8'(label_len), last: 1'b0, error: 1'b0});
        for (int i = 0; i < label_len; i++)
            expected_bytes.push_back('{wire_byte: label_buf[i], last: 1'b0, error: 1'b0});
        wire_len  += 1 + label_len;
        label_len  = 0;
    endtask

    // A rejected name gives a single error word. When the fault shows on a
    // character, the rest of the name up to its end marker is dropped.
    task automatic reject_name(bit at_end);
        expected_bytes.push_back('{wire_byte: 8'h00, last: 1'b1, error: 1'b1});
        restart_name();
        dropping = !at_end;
    endtask

    task automatic encode_word(name_word_t w);
        if (dropping) begin
            if (w.fin) begin
                dropping = 1'b0;
                restart_name();
            end
            return;
        end

        if (w.fin) begin
            if (label_len > 0) begin
                // The final label and the root byte must fit together.
                if (!label_fits(1)) begin
                    reject_name(1'b1);
                    return;
                end
                send_label();
            end else if (wire_len + 1 > dnsenc_pkg::MAX_WIRE_LEN) begin
                reject_name(1'b1);
                return;
            end
            expected_bytes.push_back('{wire_byte: 8'h00, last: 1'b1, error: 1'b0});
            restart_name();
            return;
        end

        if (w.ch == dnsenc_pkg::CHAR_DOT) begin
            if (prev_dot) begin
                reject_name(1'b0);
                return;
            end
            if (label_len > 0) begin
                if (!label_fits(0)) begin
                    reject_name(1'b0);
                    return;
                end
                send_label();
            end
            full_label_out = 1'b0;
            prev_dot       = 1'b1;
            return;
        end

        // A dot before any text, a bad character, a character past a full
        // label, or a hyphen opening a label all reject the name.
        if ((prev_dot && !seen_char) || !legal_char(w.ch) || full_label_out ||
            label_len >= dnsenc_pkg::MAX_LABEL_LEN ||
            (label_len == 0 && w.ch == dnsenc_pkg::CHAR_HYPHEN)) begin
            reject_name(1'b0);
            return;
        end

        label_buf[label_len] = w.ch;
        label_len++;
        seen_char = 1'b1;
        prev_dot  = 1'b0;

        // A label that reaches the maximum length goes out at once.
        if (label_len == dnsenc_pkg::MAX_LABEL_LEN) begin
            if (!label_fits(0)) begin
                reject_name(1'b0);
                return;
            end
            send_label();
            full_label_out = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_word(logic [7:0] ch, logic fin, bit hold);
        pending_words.push_back('{ch: ch, fin: fin, hold_for_drain: hold});
    endtask

    // All characters of a name, then its end marker with a junk character.
    task automatic push_name(string text, bit hold);
        for (int i = 0; i < text.len(); i++)
            push_word(text[i], 1'b0, hold && i == 0);
        push_word(8'($urandom_range(0, 255)), 1'b1, hold && text.len() == 0);
    endtask

    // A legal label of n characters mixing letters and digits.
    function automatic string label_of(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, "x"};
            case (i % 3)
                0:       s.putc(i, 8'("A" + i % 26));
                1:       s.putc(i, 8'("a" + i % 26));
                default: s.putc(i, 8'("0" + i % 10));
            endcase
        end
        return s;
    endfunction

    // A mostly well-formed name with random content; now and then one
    // character is overwritten by a random byte, a dot or a hyphen.
    task automatic push_random_name(output int n_words);
        string      text;
        int         labels;
        int         len;
        int         pos;
        logic [7:0] c;
        text   = "";
        labels = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3);
        for (int l = 0; l < labels; l++) begin
            if (l > 0) text = {text, "."};
            len = $urandom_range(0, 11) == 0 ? $urandom_range(20, 63) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 4))
                    0:       c = 8'("a" + $urandom_range(0, 25));
                    1:       c = 8'("A" + $urandom_range(0, 25));
                    2:       c = 8'("0" + $urandom_range(0, 9));
                    3:       c = dnsenc_pkg::CHAR_UNDERSCORE;
                    default: c = dnsenc_pkg::CHAR_HYPHEN;
                endcase
                if (c == dnsenc_pkg::CHAR_HYPHEN && (i == 0 || i == len - 1))
                    c = dnsenc_pkg::CHAR_UNDERSCORE;
                text = {text, "x"};
                text.putc(text.len() - 1, c);
            end
        end
        if ($urandom_range(0, 3) == 0) text = {text, "."};
        if (text.len() > 0 && $urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, text.len() - 1);
            case ($urandom_range(0, 2))
                0:       text.putc(pos, 8'($urandom_range(1, 255)));
                1:       text.putc(pos, dnsenc_pkg::CHAR_DOT);
                default: text.putc(pos, dnsenc_pkg::CHAR_HYPHEN);
            endcase
        end
        push_name(text, $urandom_range(0, 5) == 0);
        n_words = text.len() + 1;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers words from the pending queue in random bursts. A word
    // is fed to the predictor at the edge where it is accepted. Valid and
    // the payload are assigned at most once per edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : sender
        bit offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                encode_word(pending_words.pop_front());

            // The channel is free when nothing is offered or the offered
            // word has just been taken; otherwise valid and payload hold.
            if (!s_valid || s_ready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0 &&
                             !(pending_words[0].hold_for_drain &&
                               expected_bytes.size() != 0)) begin
                    offer = 1'b1;
                end
                if (offer) begin
                    s_char_byte <= pending_words[0].ch;
                    s_name_end  <= pending_words[0].fin;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 1;
                            1:       gap_left = $urandom_range(2, 10);
                            default: gap_left = 0;
                        endcase
                    end
                end
                s_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted output word against the oldest
    // expectation and drives m_ready from a pattern that switches between
    // always ready, coin flips, heavy stalls and a fixed duty cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : receiver
        wire_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected word: wire_byte %0h last %0b error %0b",
                           m_wire_byte, m_last, m_error);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_error !== want.error) begin
                        $error("error mismatch: expected %0b, actual %0b", want.error, m_error);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b", want.last, m_last);
                        fail_count++;
                    end
                    if (m_wire_byte !== want.wire_byte) begin
                        $error("wire_byte mismatch: expected %0h, actual %0h",
                               want.wire_byte, m_wire_byte);
                        fail_count++;
                    end
                end
            end

            ready_cycle++;
            if (ready_cycle % 97 == 0) ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (ready_cycle % 8 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_words;
        int n;
        for (int i = 0; i < dnsenc_pkg::MAX_LABEL_LEN; i++) label_buf[i] = 8'h00;

        // Directed names: empty and lone-dot names, a trailing dot, every
        // character class, each way a label can be malformed, bytes with the
        // top bit set and a zero byte, and a full-length label that goes out
        // at once and is then followed by one character too many. The first
        // word waits for an idle block, and so does the full-length label.
        push_name("", 1'b1);
        push_name(".", 1'b0);
        push_name("a", 1'b0);
        push_name("a.", 1'b0);
        push_name("Az09_-x.b-c.Zz", 1'b0);
        push_name(".a", 1'b0);
        push_name("a..b", 1'b0);
        push_name("..", 1'b0);
        push_name("-a", 1'b0);
        push_name("a-", 1'b0);
        push_name("a-.b", 1'b0);
        push_name("a b", 1'b0);
        push_word("a", 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h00, 1'b1, 1'b0);
        push_word(8'h80, 1'b0, 1'b0);
        push_word(8'h7F, 1'b1, 1'b0);
        push_name({label_of(dnsenc_pkg::MAX_LABEL_LEN), "x"}, 1'b1);

        // A few random names on top.
        random_words = 0;
        while (random_words < 10) begin
            push_random_name(n);
            random_words += n;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        // Room for a stray word after the last expected one, with margin for a full
        // label flush under receiver stalls.
        repeat (200) @(posedge aclk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
